// ----- sv/psg_pkg.sv -----
// Package for the three-voice sound generator core.
// Holds the word types, command codes, register numbers and reset constants.
// No dependencies; every other file of the block imports it.
package psg_pkg;

   localparam int VOICES              = 3;
   localparam int NUM_REGS            = 14;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Action codes of an incoming word.
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // Sound register numbers.
   localparam logic [3:0] REG_NOISE    = 4'd6;
   localparam logic [3:0] REG_MIXER    = 4'd7;
   localparam logic [3:0] REG_VOL_BASE = 4'd8;
   localparam logic [3:0] REG_ENV_LO   = 4'd11;
   localparam logic [3:0] REG_ENV_HI   = 4'd12;
   localparam logic [3:0] REG_SHAPE    = 4'd13;

   // Reset values.
   localparam logic [7:0]        MIXER_RESET        = 8'h3F;
   localparam logic [7:0]        SHAPE_RESET        = 8'h0A;
   localparam logic [16:0]       ENV_COUNT_RESET    = 17'h10000;
   localparam logic [VOICES-1:0] VOICE_ENABLE_RESET = 3'b111;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] reg_index;
      logic [7:0] write_value;
   } req_word_type;

   typedef struct packed {
      logic       is_level;
      logic [7:0] read_data;
      logic [3:0] level_a;
      logic [3:0] level_b;
      logic [3:0] level_c;
   } rsp_word_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_READ_NULL,
      CMD_TICK
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [3:0] index;
      logic [7:0] value;
   } cmd_type;

endpackage

// ----- sv/psg_front.sv -----
// Front end of the sound generator: accepts request words and classifies them.
// Depends on psg_pkg; feeds psg_queue.
module psg_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  psg_pkg::req_word_type req_data,
   input  logic                  queue_full,
   output logic                  push,
   output psg_pkg::cmd_type      push_cmd
);
   import psg_pkg::*;

   logic keep;

   // Words that have no effect (writes beyond the register file, unused
   // action code) are accepted and dropped here so they cost the back end nothing.
   always_comb begin
      keep           = 1'b0;
      push_cmd.op    = CMD_TICK;
      push_cmd.index = req_data.reg_index;
      push_cmd.value = req_data.write_value;
      case (req_data.action)
         ACT_WRITE: begin
            keep        = (req_data.reg_index < 4'(NUM_REGS));
            push_cmd.op = CMD_WRITE;
         end
         ACT_READ: begin
            keep        = 1'b1;
            push_cmd.op = (req_data.reg_index < 4'(NUM_REGS)) ? CMD_READ : CMD_READ_NULL;
         end
         ACT_TICK: begin
            keep        = 1'b1;
            push_cmd.op = CMD_TICK;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready && keep;

endmodule

// ----- sv/psg_queue.sv -----
// Command queue between the front end and the execution back end.
// Depends on psg_pkg for the command type.
module psg_queue #(
   parameter int DEPTH = psg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  psg_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output psg_pkg::cmd_type head_cmd
);
   import psg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/psg_back.sv -----
// Execution back end: sound registers, tone, noise and envelope generators,
// mixer and the registered response word. Depends on psg_pkg.
module psg_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [psg_pkg::VOICES-1:0]   csr_write_data,
   input  logic                         head_valid,
   input  psg_pkg::cmd_type             head_cmd,
   output logic                         head_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output psg_pkg::rsp_word_type        rsp_data
);
   import psg_pkg::*;

   logic [7:0]        reg_file_ff [NUM_REGS];
   logic [7:0]        reg_file_in [NUM_REGS];
   logic [VOICES-1:0] voice_enable_ff, voice_enable_in;
   logic [11:0]       tone_count_ff [VOICES];
   logic [11:0]       tone_count_in [VOICES];
   logic [VOICES-1:0] tone_phase_ff, tone_phase_in;
   logic [6:0]        noise_count_ff, noise_count_in;
   logic [16:0]       noise_shift_ff, noise_shift_in;
   logic [16:0]       env_count_ff, env_count_in;
   logic [5:0]        env_pos_ff, env_pos_in;
   logic              env_inc_ff, env_inc_in;
   logic              env_cont_ff, env_cont_in;
   logic              env_alt_ff, env_alt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_data_ff, rsp_data_in;

   // Values after one tick.
   logic [6:0]        noise_period, noise_step, tick_noise_count;
   logic              noise_hit;
   logic [16:0]       tick_noise_shift;
   logic [15:0]       env_period;
   logic              env_hit, env_turn;
   logic [5:0]        env_pos_step, tick_env_pos;
   logic              tick_env_inc, tick_env_cont, tick_env_alt;
   logic [16:0]       tick_env_count;
   logic [4:0]        env_word;
   logic [3:0]        env_level;
   logic [7:0]        shape, mixer;
   logic [11:0]       tone_period [VOICES];
   logic [11:0]       tick_tone_count [VOICES];
   logic [VOICES-1:0] tick_tone_phase;
   logic [4:0]        volume [VOICES];
   logic [3:0]        amplitude [VOICES];
   logic [3:0]        level [VOICES];

   always_comb begin
      shape = reg_file_ff[REG_SHAPE];
      mixer = reg_file_ff[REG_MIXER];

      // Noise: the shift register steps when the count reaches twice the period.
      noise_period     = {reg_file_ff[REG_NOISE][5:0], 1'b0};
      noise_step       = noise_count_ff + 7'd1;
      noise_hit        = (noise_step >= noise_period);
      tick_noise_count = noise_hit ? 7'd0 : noise_step;
      tick_noise_shift = noise_hit ? {noise_shift_ff[0] ^ noise_shift_ff[2], noise_shift_ff[16:1]}
                                   : noise_shift_ff;

      // Envelope.
      env_period = {reg_file_ff[REG_ENV_HI], reg_file_ff[REG_ENV_LO]};
      if (env_period == 16'd0) begin
         env_period = 16'd1;
      end
      env_hit        = (env_count_ff >= {1'b0, env_period});
      env_pos_step   = env_pos_ff + {5'd0, env_inc_ff};
      tick_env_pos   = env_hit ? env_pos_step : env_pos_ff;
      env_turn       = env_hit && (env_pos_step[5] != env_pos_ff[5]);
      tick_env_inc   = env_turn ? ~shape[0] : env_inc_ff;
      tick_env_cont  = env_turn ? shape[3] : env_cont_ff;
      tick_env_alt   = (env_turn && (shape[0] ^ shape[1])) ? ~env_alt_ff : env_alt_ff;
      tick_env_count = (env_hit ? 17'd0 : env_count_ff) + 17'd1;
      env_word       = (tick_env_pos[4:0] ^ {5{tick_env_alt}}) & {5{tick_env_cont}};
      env_level      = env_word[4:1];

      // Tone counters and per-voice mixing.
      for (int i = 0; i < VOICES; i++) begin
         tone_period[i] = {reg_file_ff[2 * i + 1][3:0], reg_file_ff[2 * i]};
         if (tone_period[i] == 12'd0) begin
            tone_period[i] = 12'd1;
         end
         if (tone_count_ff[i] >= tone_period[i]) begin
            tick_tone_count[i] = 12'd1;
            tick_tone_phase[i] = ~tone_phase_ff[i];
         end else begin
            tick_tone_count[i] = tone_count_ff[i] + 12'd1;
            tick_tone_phase[i] = tone_phase_ff[i];
         end
         volume[i]    = reg_file_ff[int'(REG_VOL_BASE) + i][4:0];
         amplitude[i] = volume[i][4] ? env_level : volume[i][3:0];
         level[i]     = ((tick_tone_phase[i] | mixer[i])
                         && (tick_noise_shift[0] | mixer[VOICES + i])
                         && voice_enable_ff[i]) ? amplitude[i] : 4'd0;
      end
   end

   assign head_pop = head_valid
                     && ((head_cmd.op == CMD_WRITE) || !rsp_valid_ff || rsp_ready);

   always_comb begin
      reg_file_in     = reg_file_ff;
      voice_enable_in = csr_write_enable ? csr_write_data : voice_enable_ff;
      tone_count_in   = tone_count_ff;
      tone_phase_in   = tone_phase_ff;
      noise_count_in  = noise_count_ff;
      noise_shift_in  = noise_shift_ff;
      env_count_in    = env_count_ff;
      env_pos_in      = env_pos_ff;
      env_inc_in      = env_inc_ff;
      env_cont_in     = env_cont_ff;
      env_alt_in      = env_alt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      if (head_pop) begin
         case (head_cmd.op)
            CMD_WRITE: begin
               reg_file_in[head_cmd.index] = head_cmd.value;
               if (head_cmd.index == REG_SHAPE) begin
                  // A shape write restarts the envelope; it steps on the next tick.
                  env_pos_in   = 6'd0;
                  env_inc_in   = 1'b1;
                  env_cont_in  = 1'b1;
                  env_alt_in   = ~head_cmd.value[2];
                  env_count_in = ENV_COUNT_RESET;
               end
            end
            CMD_READ: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{is_level: 1'b0, read_data: reg_file_ff[head_cmd.index],
                                level_a: 4'd0, level_b: 4'd0, level_c: 4'd0};
            end
            CMD_READ_NULL: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{is_level: 1'b0, read_data: 8'd0,
                                level_a: 4'd0, level_b: 4'd0, level_c: 4'd0};
            end
            CMD_TICK: begin
               tone_count_in  = tick_tone_count;
               tone_phase_in  = tick_tone_phase;
               noise_count_in = tick_noise_count;
               noise_shift_in = tick_noise_shift;
               env_count_in   = tick_env_count;
               env_pos_in     = tick_env_pos;
               env_inc_in     = tick_env_inc;
               env_cont_in    = tick_env_cont;
               env_alt_in     = tick_env_alt;
               rsp_valid_in   = 1'b1;
               rsp_data_in    = '{is_level: 1'b1, read_data: 8'd0,
                                  level_a: level[0], level_b: level[1], level_c: level[2]};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            reg_file_ff[r] <= (r == int'(REG_MIXER)) ? MIXER_RESET
                              : (r == int'(REG_SHAPE)) ? SHAPE_RESET : 8'd0;
         end
         voice_enable_ff        <= VOICE_ENABLE_RESET;
         tone_count_ff          <= '{default: 12'd0};
         tone_phase_ff          <= '0;
         noise_count_ff         <= 7'd0;
         noise_shift_ff         <= 17'd1;
         env_count_ff           <= ENV_COUNT_RESET;
         env_pos_ff             <= 6'd0;
         env_inc_ff             <= 1'b1;
         env_cont_ff            <= 1'b1;
         env_alt_ff             <= ~SHAPE_RESET[2];
         rsp_valid_ff           <= 1'b0;
      end else begin
         reg_file_ff     <= reg_file_in;
         voice_enable_ff <= voice_enable_in;
         tone_count_ff   <= tone_count_in;
         tone_phase_ff   <= tone_phase_in;
         noise_count_ff  <= noise_count_in;
         noise_shift_ff  <= noise_shift_in;
         env_count_ff    <= env_count_in;
         env_pos_ff      <= env_pos_in;
         env_inc_ff      <= env_inc_in;
         env_cont_ff     <= env_cont_in;
         env_alt_ff      <= env_alt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/psg_tone_noise_envelope_core.sv -----
// Top level of the three-voice tone, noise and envelope sound generator core.
// Depends on psg_pkg, psg_front, psg_queue and psg_back.
//
// This core takes one request word per clock while its queue is not full: a
// sound register write, a sound register read, or a tick that stands for one
// generation step and yields the three 4-bit channel levels. A write gives no
// response word; a read or a tick gives exactly one, in request order. Each
// word is decoded by the front end, held in a short command queue and executed
// by the back end, so the sustained rate is one word per clock while responses
// are taken. A response is registered in the output register when the back end
// takes its command from the queue; while that register is waiting to be taken,
// the queue keeps accepting words until it holds QUEUE_DEPTH of them. Writes to
// registers 14 and 15 and words with the unused action code are accepted and
// dropped in the front end. The voice enable register is written through the
// csr port; the user must write it only while the core is idle, which the core
// does not enforce. A cleared bit forces that voice's level to zero.
module psg_tone_noise_envelope_core #(
   parameter int QUEUE_DEPTH = psg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  psg_pkg::req_word_type      req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output psg_pkg::rsp_word_type      rsp_data,
   input  logic                       csr_write_enable,
   input  logic [psg_pkg::VOICES-1:0] csr_write_data
);
   import psg_pkg::*;

   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // Front end: handshake on the request side and command decode.
   psg_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // The queue lets the front end keep taking words while a response stalls.
   psg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back end: register file, generators, mixer and response register.
   psg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .head_pop         (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule
